/* rtl/swst_pkg.sv */
// ----------------------------------------------------------------------------
// swst_pkg
// types, codes and constants shared by the sliding window statistics block
// ----------------------------------------------------------------------------
package swst_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int COUNT_W        = 9;
	localparam int WIN_W          = 9;
	localparam int PERM_W         = 10;
	localparam int DEF_MAX_WINDOW = 256;
	localparam int RESET_WINDOW   = 120;
	localparam int RESET_PERMILLE = 950;
	localparam int PERM_FULL      = 1000;

	localparam logic REQ_PUSH  = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	localparam logic REG_WINDOW   = 1'b0;
	localparam logic REG_PERMILLE = 1'b1;

	typedef struct packed {
		logic                       req_type;
		logic signed [SAMPLE_W-1:0] sample;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] last_value;
		logic signed [SAMPLE_W-1:0] minimum;
		logic signed [SAMPLE_W-1:0] maximum;
		logic signed [SAMPLE_W-1:0] mean;
		logic signed [SAMPLE_W-1:0] percentile_value;
		logic [COUNT_W-1:0]         sample_count;
	} rsp_t;

	// per-cycle control broadcast to every cell of the chain
	typedef struct packed {
		logic shift;
		logic init;
		logic cmp;
	} cell_ctl_t;

endpackage

/* rtl/swst_cell.sv */
// ----------------------------------------------------------------------------
// swst_cell
// one chain cell: a sample, its valid flag and two rank counters
// ----------------------------------------------------------------------------
module swst_cell #(
	parameter int IDX = 0,
	parameter int CW  = 9
) (
	input  logic                               clk,
	input  swst_pkg::cell_ctl_t                ctl,
	input  logic [CW-1:0]                      fill,
	input  logic signed [swst_pkg::SAMPLE_W-1:0] prev_val,
	input  logic                               prev_vld,
	input  logic [CW-1:0]                      prev_lt,
	input  logic [CW-1:0]                      prev_le,
	input  logic signed [swst_pkg::SAMPLE_W-1:0] tap_val,
	input  logic                               tap_vld,
	output logic signed [swst_pkg::SAMPLE_W-1:0] val_q,
	output logic                               vld_q,
	output logic [CW-1:0]                      lt_q,
	output logic [CW-1:0]                      le_q
);
	import swst_pkg::*;

	localparam logic [31:0] IDX_C = 32'(IDX);

	logic inc_lt, inc_le;

	assign inc_lt = ctl.cmp && tap_vld && (tap_val < prev_val);
	assign inc_le = ctl.cmp && tap_vld && (tap_val <= prev_val);

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			vld_q <= IDX_C < 32'(fill);
			lt_q  <= '0;
			le_q  <= '0;
		end else if (ctl.shift) begin
			val_q <= prev_val;
			vld_q <= prev_vld;
			lt_q  <= prev_lt + CW'(inc_lt);
			le_q  <= prev_le + CW'(inc_le);
		end
	end

endmodule

/* rtl/swst_div.sv */
// ----------------------------------------------------------------------------
// swst_div
// restoring divider, signed dividend by unsigned divisor, one bit per cycle
// ----------------------------------------------------------------------------
module swst_div #(
	parameter int NW = 41,
	parameter int DW = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] dividend,
	input  logic [DW-1:0]        divisor,
	output logic                 busy,
	output logic signed [NW-1:0] quotient
);
	import swst_pkg::*;

	localparam int KW = $clog2(NW + 1);

	logic [NW-1:0] mag_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [KW-1:0] cnt_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, mag_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign busy  = cnt_q != '0;
	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= KW'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[NW-1];
			mag_q <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : DW'(trial);
			mag_q <= {mag_q[NW-2:0], fits};
		end
	end

endmodule

/* rtl/sliding_window_statistics.sv */
// ----------------------------------------------------------------------------
// sliding_window_statistics
// min, max, mean and nearest-rank percentile over the most recent samples
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_stall/in_data) takes one item, a push of a q16.16
//   sample or a clear of the window. every item gives exactly one snapshot
//   item on the out channel (out_valid/out_stall/out_data).
//   window_size and percentile_permille sit on the apb port at 0x0 and 0x4;
//   a window_size write acts at the next clear.
//   an item is taken only in idle, so a new item waits until the last one is
//   through: the init step, two full turns of the cell chain (one to count
//   ranks, min, max and sum, one to pick the percentile sample at the tap)
//   and the done step, plus any wait for the divider when MAX_WINDOW is
//   below about 40.
//   in_stall is high while an item is in work; a finished snapshot waits in
//   the output register, and the next item is taken while it waits.
//   if the receiver stalls, the snapshot holds and the next item finishing
//   waits until the output register is free.
//   reset: empty window, window size 120, permille 950; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_statistics #(
	parameter int MAX_WINDOW = swst_pkg::DEF_MAX_WINDOW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  swst_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output swst_pkg::rsp_t out_data,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import swst_pkg::*;

	localparam int CW   = $clog2(MAX_WINDOW + 1);
	localparam int IW   = $clog2(MAX_WINDOW);
	localparam int SUMW = SAMPLE_W + $clog2(MAX_WINDOW) + 1;
	// rank math: k = ceil(p*n/1000) by reciprocal multiply
	localparam int PW   = PERM_W + CW;
	localparam int XW   = PW + 1;
	localparam int SH   = XW + 10;
	localparam int MW   = SH - 9;
	localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'd999) / 64'd1000;
	localparam logic [IW-1:0] LAST_STEP = IW'(MAX_WINDOW - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_INIT = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_FIND = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;

	// configuration
	logic [WIN_W-1:0]  win_q;
	logic [PERM_W-1:0] perm_q;
	logic              cfg_wr;

	// window control
	logic [CW-1:0] act_q;
	logic [CW-1:0] fill_q;
	logic signed [SAMPLE_W-1:0] last_q;
	logic [CW-1:0] clamp_win;
	logic          in_acc;
	logic          push_acc;

	// statistics
	logic [IW-1:0]              step_q;
	logic signed [SAMPLE_W-1:0] min_q, max_q, pct_q;
	logic signed [SUMW-1:0]     sum_q;
	logic [PW-1:0]              pn_q;
	logic [CW-1:0]              k_q;
	logic [CW-1:0]              rank;
	logic [PERM_W-1:0]          perm_eff;
	logic [XW+MW-1:0]           kprod;

	// divider
	logic                   div_start;
	logic                   div_busy;
	logic signed [SUMW-1:0] div_q;

	// output
	logic out_valid_q;
	rsp_t out_q;
	logic finish;

	// chain
	cell_ctl_t ctl;
	logic signed [SAMPLE_W-1:0] c_val [MAX_WINDOW];
	logic                       c_vld [MAX_WINDOW];
	logic [CW-1:0]              c_lt  [MAX_WINDOW];
	logic [CW-1:0]              c_le  [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] head_val;
	logic signed [SAMPLE_W-1:0] tap_val;
	logic                       tap_vld;
	logic [CW-1:0]              tap_lt, tap_le;

	// ---------------- apb port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= WIN_W'(RESET_WINDOW);
			perm_q <= PERM_W'(RESET_PERMILLE);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WINDOW:   win_q  <= pwdata[WIN_W-1:0];
				REG_PERMILLE: perm_q <= pwdata[PERM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW:   prdata = 32'(win_q);
			REG_PERMILLE: prdata = 32'(perm_q);
			default:      prdata = '0;
		endcase
	end

	// zero acts as one, oversize saturates at the chain length
	always_comb begin
		if (win_q == '0) begin
			clamp_win = CW'(1);
		end else if (32'(win_q) > 32'(MAX_WINDOW)) begin
			clamp_win = CW'(MAX_WINDOW);
		end else begin
			clamp_win = CW'(win_q);
		end
	end

	// ---------------- sequencer ----------------
	assign in_stall = state_q != ST_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign push_acc = in_acc && (in_data.req_type == REQ_PUSH);
	assign finish   = (state_q == ST_DONE) && !div_busy && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			act_q   <= (RESET_WINDOW > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(RESET_WINDOW);
			fill_q  <= '0;
			last_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_INIT;
						if (in_data.req_type == REQ_CLEAR) begin
							act_q  <= clamp_win;
							fill_q <= '0;
							last_q <= '0;
						end else begin
							last_q <= in_data.sample;
							if (fill_q < act_q) begin
								fill_q <= fill_q + 1'b1;
							end
						end
					end
				end
				ST_INIT: begin
					step_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						state_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- cell chain ----------------
	// a push shifts the new sample in at the head; a turn feeds the tap back
	assign ctl.shift = push_acc || (state_q == ST_SCAN) || (state_q == ST_FIND);
	assign ctl.init  = state_q == ST_INIT;
	assign ctl.cmp   = state_q == ST_SCAN;

	assign tap_val  = c_val[MAX_WINDOW-1];
	assign tap_vld  = c_vld[MAX_WINDOW-1];
	assign tap_lt   = c_lt[MAX_WINDOW-1];
	assign tap_le   = c_le[MAX_WINDOW-1];
	assign head_val = push_acc ? in_data.sample : tap_val;

	swst_cell #(.IDX(0), .CW(CW)) u_cell_head (
		.clk      (clk),
		.ctl      (ctl),
		.fill     (fill_q),
		.prev_val (head_val),
		.prev_vld (tap_vld),
		.prev_lt  (tap_lt),
		.prev_le  (tap_le),
		.tap_val  (tap_val),
		.tap_vld  (tap_vld),
		.val_q    (c_val[0]),
		.vld_q    (c_vld[0]),
		.lt_q     (c_lt[0]),
		.le_q     (c_le[0])
	);

	for (genvar g = 1; g < MAX_WINDOW; g++) begin : g_cell
		swst_cell #(.IDX(g), .CW(CW)) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.fill     (fill_q),
			.prev_val (c_val[g-1]),
			.prev_vld (c_vld[g-1]),
			.prev_lt  (c_lt[g-1]),
			.prev_le  (c_le[g-1]),
			.tap_val  (tap_val),
			.tap_vld  (tap_vld),
			.val_q    (c_val[g]),
			.vld_q    (c_vld[g]),
			.lt_q     (c_lt[g]),
			.le_q     (c_le[g])
		);
	end

	// ---------------- statistics at the tap ----------------
	assign perm_eff = (perm_q > PERM_W'(PERM_FULL)) ? PERM_W'(PERM_FULL) : perm_q;
	assign kprod    = (XW'(pn_q) + XW'(999)) * (XW+MW)'(RECIP[MW-1:0]);

	always_comb begin
		rank = (k_q == '0) ? '0 : k_q - 1'b1;
		if (fill_q != '0 && rank > fill_q - 1'b1) begin
			rank = fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			min_q <= {1'b0, {(SAMPLE_W-1){1'b1}}};
			max_q <= {1'b1, {(SAMPLE_W-1){1'b0}}};
			sum_q <= '0;
			pn_q  <= PW'(perm_eff) * PW'(fill_q);
			pct_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			k_q <= kprod[SH +: CW];
			if (tap_vld) begin
				if (tap_val < min_q) min_q <= tap_val;
				if (tap_val > max_q) max_q <= tap_val;
				sum_q <= sum_q + SUMW'(tap_val);
			end
		end
		// ranks are complete; the sample whose rank span covers the target wins
		if (state_q == ST_FIND && tap_vld && tap_lt <= rank && rank < tap_le) begin
			pct_q <= tap_val;
		end
	end

	assign div_start = (state_q == ST_FIND) && (step_q == '0);

	swst_div #(.NW(SUMW), .DW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (fill_q),
		.busy     (div_busy),
		.quotient (div_q)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.last_value   <= last_q;
			out_q.sample_count <= COUNT_W'(fill_q);
			if (fill_q == '0) begin
				out_q.minimum          <= '0;
				out_q.maximum          <= '0;
				out_q.mean             <= '0;
				out_q.percentile_value <= '0;
			end else begin
				out_q.minimum          <= min_q;
				out_q.maximum          <= max_q;
				out_q.mean             <= div_q[SAMPLE_W-1:0];
				out_q.percentile_value <= pct_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
